// ===== sv/mxt_pkg.sv =====
package mxt_pkg;

    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_FIX_CHECKSUMS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_KEY    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MARKER_PATTERN = 2'd2;

    localparam logic        RST_FIX_CHECKSUMS  = 1'b0;
    localparam logic [7:0]  RST_INITIAL_KEY    = 8'd37;
    localparam logic [23:0] RST_MARKER_PATTERN = 24'd5458776;

    typedef enum logic [1:0] {
        PHASE_LEN_LO,
        PHASE_LEN_HI,
        PHASE_BODY
    } phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic       enc;
        logic       load;
        logic       last;
    } raw_word_t;

endpackage

// ===== sv/marker_xor_tap_checksum_stream.sv =====
// Order: a word released by an accepted input word passes the burst buffer and then the
// output register of the tap; the marker look-ahead holds the two most recent words, so
// output trails input by two words.
// Throughput: one word per cycle while the output accepts; an end-of-file word flushes up
// to three words through the three-word burst buffer, and the input stalls meanwhile.
// Reset: rst_n is asynchronous, active low; it clears the stream state and loads the
// register defaults (checksum fix off, key 37, marker "SKX").
module marker_xor_tap_checksum_stream (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // end_of_file
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast,   // out_last
    output logic [1:0]  m_tuser,   // [0] marker_found, [1] checksum_changed
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [mxt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [23:0] cfg_data
);
    import mxt_pkg::*;

    logic        fix_reg;
    logic [7:0]  key_reg;
    logic [23:0] marker_reg;

    logic        raw_valid;
    logic        raw_ready;
    raw_word_t   raw;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fix_reg    <= RST_FIX_CHECKSUMS;
            key_reg    <= RST_INITIAL_KEY;
            marker_reg <= RST_MARKER_PATTERN;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_FIX_CHECKSUMS:  fix_reg    <= cfg_data[0];
                CFG_INITIAL_KEY:    key_reg    <= cfg_data[7:0];
                CFG_MARKER_PATTERN: marker_reg <= cfg_data;
                default:            fix_reg    <= fix_reg;
            endcase
        end
    end

    mxt_window u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_valid   (s_tvalid),
        .s_ready   (s_tready),
        .s_data    (s_tdata),
        .s_last    (s_tlast),
        .marker    (marker_reg),
        .raw_valid (raw_valid),
        .raw_ready (raw_ready),
        .raw       (raw)
    );

    mxt_tap u_tap (
        .clk       (clk),
        .rst_n     (rst_n),
        .raw_valid (raw_valid),
        .raw_ready (raw_ready),
        .raw       (raw),
        .fix       (fix_reg),
        .init_key  (key_reg),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_data    (m_tdata),
        .m_last    (m_tlast),
        .m_user    (m_tuser)
    );

endmodule

// ===== sv/mxt_window.sv =====
module mxt_window (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_data,
    input  logic              s_last,
    input  logic [23:0]       marker,
    output logic              raw_valid,
    input  logic              raw_ready,
    output mxt_pkg::raw_word_t raw
);
    import mxt_pkg::*;

    logic [7:0] win_reg [2];
    logic [7:0] win_next [2];
    logic [1:0] fill_reg, fill_next;
    logic       encrypting_reg, encrypting_next;

    logic [7:0] burst_reg [3];
    logic [7:0] burst_next [3];
    logic [1:0] cnt_reg, cnt_next;
    logic       benc_reg, benc_next;
    logic       load_reg, load_next;
    logic       eof_reg, eof_next;

    logic drain;
    logic accept;
    logic match;
    logic enc_now;

    assign drain     = (cnt_reg != 2'd0) && raw_ready;
    assign s_ready   = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && raw_ready);
    assign accept    = s_valid && s_ready;
    assign raw_valid = (cnt_reg != 2'd0);

    assign raw.data = burst_reg[0];
    assign raw.enc  = benc_reg;
    assign raw.load = load_reg;
    assign raw.last = eof_reg && (cnt_reg == 2'd1);

    assign match = (fill_reg == 2'd2) && !encrypting_reg
                   && (win_reg[0] == marker[23:16])
                   && (win_reg[1] == marker[15:8])
                   && (s_data == marker[7:0]);
    assign enc_now = encrypting_reg || match;

    always_comb
    begin
        win_next        = win_reg;
        fill_next       = fill_reg;
        encrypting_next = encrypting_reg;
        burst_next      = burst_reg;
        cnt_next        = cnt_reg;
        benc_next       = benc_reg;
        load_next       = load_reg;
        eof_next        = eof_reg;

        // advance the burst by one word
        if (drain)
        begin
            burst_next[0] = burst_reg[1];
            burst_next[1] = burst_reg[2];
            cnt_next      = cnt_reg - 2'd1;
            load_next     = 1'b0;
        end

        if (accept)
        begin
            if (!s_last)
            begin
                if (fill_reg == 2'd2)
                begin
                    burst_next[0]   = win_reg[0];
                    cnt_next        = 2'd1;
                    benc_next       = enc_now;
                    load_next       = match;
                    eof_next        = 1'b0;
                    win_next[0]     = win_reg[1];
                    win_next[1]     = s_data;
                    encrypting_next = enc_now;
                end
                else
                begin
                    win_next[fill_reg[0]] = s_data;
                    fill_next             = fill_reg + 2'd1;
                end
            end
            else
            begin
                case (fill_reg)
                    2'd0:
                    begin
                        burst_next[0] = s_data;
                        cnt_next      = 2'd1;
                    end
                    2'd1:
                    begin
                        burst_next[0] = win_reg[0];
                        burst_next[1] = s_data;
                        cnt_next      = 2'd2;
                    end
                    default:
                    begin
                        burst_next[0] = win_reg[0];
                        burst_next[1] = win_reg[1];
                        burst_next[2] = s_data;
                        cnt_next      = 2'd3;
                    end
                endcase
                benc_next       = enc_now;
                load_next       = match;
                eof_next        = 1'b1;
                // restart the stream
                fill_next       = 2'd0;
                encrypting_next = 1'b0;
                win_next[0]     = 8'd0;
                win_next[1]     = 8'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg[0]     <= 8'd0;
            win_reg[1]     <= 8'd0;
            fill_reg       <= 2'd0;
            encrypting_reg <= 1'b0;
            cnt_reg        <= 2'd0;
            benc_reg       <= 1'b0;
            load_reg       <= 1'b0;
            eof_reg        <= 1'b0;
        end
        else
        begin
            win_reg        <= win_next;
            fill_reg       <= fill_next;
            encrypting_reg <= encrypting_next;
            cnt_reg        <= cnt_next;
            benc_reg       <= benc_next;
            load_reg       <= load_next;
            eof_reg        <= eof_next;
        end
    end

    always_ff @(posedge clk)
    begin
        burst_reg <= burst_next;
    end

endmodule

// ===== sv/mxt_tap.sv =====
module mxt_tap (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               raw_valid,
    output logic               raw_ready,
    input  mxt_pkg::raw_word_t raw,
    input  logic               fix,
    input  logic [7:0]         init_key,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_data,
    output logic               m_last,
    output logic [1:0]         m_user
);
    import mxt_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] rem_reg, rem_next;
    logic [7:0]  csum_reg, csum_next;
    logic [7:0]  key_reg, key_next;

    logic        mv_reg;
    logic [7:0]  od_reg;
    logic        olast_reg;
    logic        ofound_reg;
    logic        ochg_reg;

    logic        take;
    logic [7:0]  key_sel;
    logic [7:0]  b_enc;
    logic [15:0] len_full;
    logic        rem_end;
    logic [7:0]  byte_out;
    logic        changed;

    assign raw_ready = !mv_reg || m_ready;
    assign take      = raw_valid && raw_ready;

    assign key_sel  = raw.load ? init_key : key_reg;
    assign b_enc    = raw.enc ? (raw.data ^ key_sel) : raw.data;
    assign len_full = {b_enc, len_reg[7:0]};
    assign rem_end  = (rem_reg <= 16'd1);

    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PHASE_LEN_LO: phase_next = PHASE_LEN_HI;
            PHASE_LEN_HI: phase_next = (len_full == 16'd0) ? PHASE_LEN_LO : PHASE_BODY;
            PHASE_BODY:   phase_next = rem_end ? PHASE_LEN_LO : PHASE_BODY;
            default:      phase_next = PHASE_LEN_LO;
        endcase
        if (raw.last)
        begin
            phase_next = PHASE_LEN_LO;
        end
    end

    always_comb
    begin
        len_next  = len_reg;
        rem_next  = rem_reg;
        csum_next = csum_reg;
        byte_out  = b_enc;
        changed   = 1'b0;
        key_next  = raw.enc ? key_sel + 8'd1 : key_reg;
        case (phase_reg)
            PHASE_LEN_LO:
            begin
                len_next = {8'd0, b_enc};
            end
            PHASE_LEN_HI:
            begin
                len_next = len_full;
                if (len_full != 16'd0)
                begin
                    rem_next  = len_full;
                    csum_next = 8'd0;
                end
            end
            PHASE_BODY:
            begin
                if (rem_end)
                begin
                    if (fix && (len_reg > 16'd1))
                    begin
                        changed  = (b_enc != csum_reg);
                        byte_out = csum_reg;
                    end
                    rem_next = 16'd0;
                end
                else
                begin
                    csum_next = csum_reg ^ b_enc;
                    rem_next  = rem_reg - 16'd1;
                end
            end
            default:
            begin
                len_next = len_reg;
            end
        endcase
        if (raw.last)
        begin
            len_next  = 16'd0;
            rem_next  = 16'd0;
            csum_next = 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PHASE_LEN_LO;
            len_reg   <= 16'd0;
            rem_reg   <= 16'd0;
            csum_reg  <= 8'd0;
            key_reg   <= RST_INITIAL_KEY;
            mv_reg    <= 1'b0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            rem_reg   <= rem_next;
            csum_reg  <= csum_next;
            key_reg   <= key_next;
            mv_reg    <= 1'b1;
        end
        else if (m_ready)
        begin
            mv_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            od_reg     <= byte_out;
            olast_reg  <= raw.last;
            ofound_reg <= raw.last && raw.enc;
            ochg_reg   <= changed;
        end
    end

    assign m_valid = mv_reg;
    assign m_data  = od_reg;
    assign m_last  = olast_reg;
    assign m_user  = {ochg_reg, ofound_reg};

endmodule

// ===== sv/mxt_checker.sv =====
module mxt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tlast,
    input logic [1:0]  m_tuser
);

    // marker flag only rides on the final word of a file
    a_found_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> m_tlast)
        else $error("marker_found set on a word that is not last");

    // a stalled input means a word is pending for the output
    a_stall_has_output: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |=> m_tvalid)
        else $error("input stalled with no output word following");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)
                                     && $stable(m_tlast) && $stable(m_tuser)))
        else $error("stalled output word changed");

endmodule

bind marker_xor_tap_checksum_stream mxt_checker u_mxt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
